/* rtl/sfc_pkg.sv */
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types and constants for the symmetric complex FIR filter.
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int COEF_W           = 16;
  localparam int CFG_IDX_W        = 8;
  localparam int NUM_COEF         = 8;
  localparam int COEF_IDX_W       = 3;
  localparam int DEF_TAP_COUNT    = 16;
  localparam int DEF_OUTPUT_SHIFT = 15;

  localparam logic signed [COEF_W-1:0] COEF_RESET [NUM_COEF] = '{
    -16'sd1000, 16'sd2000, -16'sd3000, 16'sd4000,
    -16'sd5000, 16'sd6000, -16'sd7000, 16'sd8000
  };

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
  } cplx_t;

  typedef struct packed {
    logic shift;
    logic rotate;
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

endpackage

/* rtl/sfc_if.sv */
// ----------------------------------------------------------------------------
// sfc interfaces
// Valid/ready channels for samples, filtered words and coefficient writes.
// ----------------------------------------------------------------------------
interface sfc_sample_if
  import sfc_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_re;
  logic signed [SAMPLE_W-1:0] sample_im;

  modport source (output valid, output sample_re, output sample_im, input ready);
  modport sink   (input valid, input sample_re, input sample_im, output ready);
endinterface

interface sfc_result_if
  import sfc_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] filtered_re;
  logic signed [SAMPLE_W-1:0] filtered_im;

  modport source (output valid, output filtered_re, output filtered_im, input ready);
  modport sink   (input valid, input filtered_re, input filtered_im, output ready);
endinterface

interface sfc_cfg_if
  import sfc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/sfc_tap_cell.sv */
// ----------------------------------------------------------------------------
// sfc_tap_cell
// One complex sample slot of the tap ring; shifts in or rotates toward tap 0.
// ----------------------------------------------------------------------------
module sfc_tap_cell
  import sfc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  cplx_t      left_i,
  input  cplx_t      right_i,
  output cplx_t      q_o
);

  cplx_t q_q;
  cplx_t q_d;

  always_comb begin
    q_d = q_q;
    if (ctrl_i.shift) begin
      q_d = left_i;
    end else if (ctrl_i.rotate) begin
      q_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= '0;
    end else begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

/* rtl/sfc_mac.sv */
// ----------------------------------------------------------------------------
// sfc_mac
// Shared complex-by-real multiply-accumulate with floor shift and saturation.
// ----------------------------------------------------------------------------
module sfc_mac
  import sfc_pkg::*;
#(
  parameter int TAP_COUNT    = DEF_TAP_COUNT,
  parameter int OUTPUT_SHIFT = DEF_OUTPUT_SHIFT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mac_ctrl_t                ctrl_i,
  input  logic signed [COEF_W-1:0] coef_i,
  input  cplx_t                    sample_i,
  output cplx_t                    res_o
);

  localparam int PROD_W = COEF_W + SAMPLE_W;
  localparam int ACC_W  = PROD_W + $clog2(TAP_COUNT);

  localparam logic signed [ACC_W-1:0] SAT_MAX = {{(ACC_W-SAMPLE_W+1){1'b0}},
                                                 {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN = {{(ACC_W-SAMPLE_W+1){1'b1}},
                                                 {(SAMPLE_W-1){1'b0}}};

  logic signed [PROD_W-1:0] prod_re_q, prod_im_q;
  logic                     prod_vld_q;
  logic signed [ACC_W-1:0]  acc_re_q, acc_im_q;
  logic signed [ACC_W-1:0]  acc_re_d, acc_im_d;
  logic signed [ACC_W-1:0]  sh_re, sh_im;

  always_ff @(posedge clk_i) begin
    prod_re_q <= coef_i * sample_i.re;
    prod_im_q <= coef_i * sample_i.im;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.issue;
    end
  end

  always_comb begin
    acc_re_d = acc_re_q;
    acc_im_d = acc_im_q;
    if (ctrl_i.clear) begin
      acc_re_d = '0;
      acc_im_d = '0;
    end else if (prod_vld_q) begin
      acc_re_d = acc_re_q + ACC_W'(prod_re_q);
      acc_im_d = acc_im_q + ACC_W'(prod_im_q);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_re_q <= acc_re_d;
    acc_im_q <= acc_im_d;
  end

  // arithmetic shift gives floor rounding
  assign sh_re = acc_re_q >>> OUTPUT_SHIFT;
  assign sh_im = acc_im_q >>> OUTPUT_SHIFT;

  always_comb begin
    if (sh_re > SAT_MAX) begin
      res_o.re = SAT_MAX[SAMPLE_W-1:0];
    end else if (sh_re < SAT_MIN) begin
      res_o.re = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      res_o.re = sh_re[SAMPLE_W-1:0];
    end
    if (sh_im > SAT_MAX) begin
      res_o.im = SAT_MAX[SAMPLE_W-1:0];
    end else if (sh_im < SAT_MIN) begin
      res_o.im = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      res_o.im = sh_im[SAMPLE_W-1:0];
    end
  end

endmodule

/* rtl/symmetric_fir_complex16_core.sv */
// ----------------------------------------------------------------------------
// symmetric_fir_complex16_core
// Symmetric-coefficient FIR on a complex 16-bit sample stream.
// ----------------------------------------------------------------------------
// Channels: sample_i takes one complex word per sample, result_o returns one
// filtered complex word per sample, cfg_i writes coefficient registers 0..7
// (other indexes are dropped). Write coefficients only while idle.
// The samples sit in a ring of TAP_COUNT cells. After a word is accepted the
// ring rotates once per cycle past a single shared multiply-accumulate, one tap
// per cycle, then the DRAIN state empties the product register.
// A new word is taken only in IDLE, after the last one has left DONE, since the
// one multiplier pair steps through the taps.
// Reset clears the sample ring and loads the default coefficients; the block
// is ready to accept a word as soon as reset is released.
// If the receiver stalls, the finished word waits in the output register and
// the next filtered word is held back until it is taken.
// ----------------------------------------------------------------------------
module symmetric_fir_complex16_core
  import sfc_pkg::*;
#(
  parameter int TAP_COUNT    = DEF_TAP_COUNT,
  parameter int OUTPUT_SHIFT = DEF_OUTPUT_SHIFT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sfc_sample_if.sink  sample_i,
  sfc_result_if.source result_o,
  sfc_cfg_if.sink     cfg_i
);

  localparam int K_W   = $clog2(TAP_COUNT);
  localparam int SEL_W = (K_W > COEF_IDX_W) ? K_W : COEF_IDX_W;

  state_e state_q, state_d;
  logic [K_W-1:0] k_q, k_d;
  logic signed [COEF_W-1:0] coef_q [NUM_COEF];
  logic        out_valid_q;
  cplx_t       out_q;

  logic        in_acc;
  logic        out_free;
  logic        load_out;
  cell_ctrl_t  cell_ctrl;
  mac_ctrl_t   mac_ctrl;
  cplx_t       new_word;
  cplx_t       ring [TAP_COUNT];
  cplx_t       res;
  logic [K_W-1:0]  mirror;
  logic [K_W-1:0]  jsel;
  logic [SEL_W-1:0] jsel_ext;
  logic signed [COEF_W-1:0] coef_sel;

  assign sample_i.ready = (state_q == ST_IDLE);
  assign in_acc   = sample_i.valid && sample_i.ready;
  assign out_free = !out_valid_q || result_o.ready;
  assign load_out = (state_q == ST_DONE) && out_free;
  assign cfg_i.ready = 1'b1;

  assign new_word.re = sample_i.sample_re;
  assign new_word.im = sample_i.sample_im;

  assign cell_ctrl.shift  = in_acc;
  assign cell_ctrl.rotate = (state_q == ST_RUN);
  assign mac_ctrl.clear   = in_acc;
  assign mac_ctrl.issue   = (state_q == ST_RUN);

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        k_d = '0;
        if (in_acc) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        k_d = k_q + 1'b1;
        if (k_q == K_W'(TAP_COUNT - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  // tap k and its mirror share a coefficient; pairs past the register set use 0
  assign mirror   = K_W'(TAP_COUNT - 1) - k_q;
  assign jsel     = (k_q < mirror) ? k_q : mirror;
  assign jsel_ext = SEL_W'(jsel);

  always_comb begin
    if (jsel_ext < SEL_W'(NUM_COEF)) begin
      coef_sel = coef_q[jsel_ext[COEF_IDX_W-1:0]];
    end else begin
      coef_sel = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_q[i] <= COEF_RESET[i];
      end
    end else if (cfg_i.valid && cfg_i.ready && (cfg_i.index < CFG_IDX_W'(NUM_COEF))) begin
      coef_q[cfg_i.index[COEF_IDX_W-1:0]] <= cfg_i.data;
    end
  end

  for (genvar g = 0; g < TAP_COUNT; g++) begin : g_cell
    cplx_t left;
    if (g == 0) begin : g_head
      assign left = new_word;
    end else begin : g_body
      assign left = ring[g-1];
    end
    sfc_tap_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .left_i  (left),
      .right_i (ring[(g + 1) % TAP_COUNT]),
      .q_o     (ring[g])
    );
  end

  sfc_mac #(
    .TAP_COUNT    (TAP_COUNT),
    .OUTPUT_SHIFT (OUTPUT_SHIFT)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .coef_i   (coef_sel),
    .sample_i (ring[0]),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= res;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.filtered_re = out_q.re;
  assign result_o.filtered_im = out_q.im;

endmodule
